/* hdl/mgc_pkg.sv */
// mgc_pkg: shared types, widths and constants for the microphone DC removal,
// gain, clip and gain control block. No dependencies.
package mgc_pkg;

	localparam int SAMPLE_BITS    = 16;
	localparam int DC_BITS        = 16;
	localparam int GAIN_BITS      = 10;
	localparam int SKIP_BITS      = 8;
	localparam int CFG_DATA_BITS  = 16;
	localparam int CFG_INDEX_BITS = 2;

	// magnitude of raw minus offset
	localparam int DIFF_BITS   = (SAMPLE_BITS > DC_BITS) ? SAMPLE_BITS : DC_BITS;
	localparam int PROD_BITS   = DIFF_BITS + GAIN_BITS;
	// magnitude of an unclipped product always fits here
	localparam int QMAG_BITS   = SAMPLE_BITS + 6;
	localparam int RECIP_SHIFT = QMAG_BITS + 7;
	localparam int GAIN_DIV    = 100;

	localparam logic [DC_BITS-1:0]   DC_OFFSET_RST = DC_BITS'(11000);
	localparam logic [GAIN_BITS-1:0] START_GAIN_RST = GAIN_BITS'(300);
	localparam logic [SKIP_BITS-1:0] SKIP_FRAMES_RST = SKIP_BITS'(2);
	localparam logic [GAIN_BITS-1:0] GAIN_FLOOR = GAIN_BITS'(GAIN_DIV);
	localparam logic [SKIP_BITS-1:0] FRAMES_MAX = {SKIP_BITS{1'b1}};

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_DC_OFFSET   = 2'd0,
		REG_START_GAIN  = 2'd1,
		REG_SKIP_FRAMES = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] raw_sample;
		logic                          frame_end;
	} sample_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] clean_sample;
		logic                          clipped;
		logic                          frame_last;
		logic [GAIN_BITS-1:0]          gain_used;
	} result_t;

	typedef struct packed {
		logic                 neg;
		logic [DIFF_BITS-1:0] mag;
		logic                 last;
	} diff_t;

	typedef struct packed {
		logic                 neg;
		logic                 clip;
		logic [QMAG_BITS-1:0] mag;
		logic                 last;
		logic [GAIN_BITS-1:0] gain;
	} prod_t;

endpackage

/* hdl/mic_dc_gain_clip_agc.sv */
// mic_dc_gain_clip_agc: top level of the microphone conditioning block.
// Depends on mgc_pkg, mgc_cond, mgc_agc and mgc_out.
//
//   channel  direction  handshake                  payload
//   cfg      in         cfg_valid / cfg_ready      cfg_index, cfg_data
//   sample   in         sample_valid / sample_ready  sample (sample_t)
//   result   out        result_valid / result_ready  result (result_t)
//
// One item per cycle sustained; three register stages (offset, multiply/clip,
// divide/saturate) lie between an accepted item and its result_valid.
// Items from skipped frames give no result. Reset clears the config registers
// to their defaults and empties all stages. A stall on result backs up stage
// by stage; sample_ready drops only when every stage is full.
module mic_dc_gain_clip_agc import mgc_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data,
	input  logic                      sample_valid,
	output logic                      sample_ready,
	input  sample_t                   sample,
	output logic                      result_valid,
	input  logic                      result_ready,
	output result_t                   result
);

	logic signed [DC_BITS-1:0] dc_offset;
	diff_t                     diff;
	logic                      diff_valid;
	logic                      diff_ready;
	prod_t                     prod;
	logic                      prod_valid;
	logic                      prod_ready;

	mgc_cond u_cond (
		.clk          (clk),
		.arst_n       (arst_n),
		.dc_offset    (dc_offset),
		.sample       (sample),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.diff         (diff),
		.diff_valid   (diff_valid),
		.diff_ready   (diff_ready)
	);

	mgc_agc u_agc (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.dc_offset  (dc_offset),
		.diff       (diff),
		.diff_valid (diff_valid),
		.diff_ready (diff_ready),
		.prod       (prod),
		.prod_valid (prod_valid),
		.prod_ready (prod_ready)
	);

	mgc_out u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.prod         (prod),
		.prod_valid   (prod_valid),
		.prod_ready   (prod_ready),
		.result       (result),
		.result_valid (result_valid),
		.result_ready (result_ready)
	);

endmodule

/* hdl/mgc_cond.sv */
// mgc_cond: input stage. Removes the DC offset and registers sign and
// magnitude of the difference. Uses mgc_pkg.
module mgc_cond import mgc_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic signed [DC_BITS-1:0] dc_offset,
	input  sample_t                   sample,
	input  logic                      sample_valid,
	output logic                      sample_ready,
	output diff_t                     diff,
	output logic                      diff_valid,
	input  logic                      diff_ready
);

	logic signed [DIFF_BITS:0] raw_x;
	logic signed [DIFF_BITS:0] dc_x;
	logic signed [DIFF_BITS:0] d;
	logic [DIFF_BITS:0]        neg_d;
	logic                      valid_s1;
	diff_t                     diff_s1;

	assign raw_x = (DIFF_BITS+1)'(sample.raw_sample);
	assign dc_x  = (DIFF_BITS+1)'(dc_offset);
	assign d     = raw_x - dc_x;
	assign neg_d = -d;

	assign sample_ready = !valid_s1 || diff_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample_ready) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_valid && sample_ready) begin
			diff_s1.neg  <= d[DIFF_BITS];
			diff_s1.mag  <= d[DIFF_BITS] ? neg_d[DIFF_BITS-1:0] : d[DIFF_BITS-1:0];
			diff_s1.last <= sample.frame_end;
		end
	end

	assign diff       = diff_s1;
	assign diff_valid = valid_s1;

endmodule

/* hdl/mgc_agc.sv */
// mgc_agc: configuration registers, frame skip, gain multiply, clip detect and
// per-frame gain decrement. Uses mgc_pkg.
module mgc_agc import mgc_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [CFG_DATA_BITS-1:0]  cfg_data,
	output logic signed [DC_BITS-1:0] dc_offset,
	input  diff_t                     diff,
	input  logic                      diff_valid,
	output logic                      diff_ready,
	output prod_t                     prod,
	output logic                      prod_valid,
	input  logic                      prod_ready
);

	localparam logic [PROD_BITS-1:0] HALF_RANGE = PROD_BITS'(1) << (SAMPLE_BITS - 1);
	localparam logic [PROD_BITS-1:0] POS_LIM = HALF_RANGE * PROD_BITS'(GAIN_DIV);
	localparam logic [PROD_BITS-1:0] NEG_LIM = POS_LIM + PROD_BITS'(GAIN_DIV);

	logic [DC_BITS-1:0]   dc_offset_q;
	logic [SKIP_BITS-1:0] skip_q;
	logic [GAIN_BITS-1:0] gain_q;
	logic [SKIP_BITS-1:0] frames_q;
	logic                 clip_seen_q;
	logic                 valid_s2;
	prod_t                prod_s2;

	logic                 drop;
	logic                 fire;
	logic [PROD_BITS-1:0] p;
	logic                 clip;

	assign cfg_ready = 1'b1;
	assign dc_offset = dc_offset_q;

	assign drop       = frames_q < skip_q;
	assign diff_ready = drop || !valid_s2 || prod_ready;
	assign fire       = diff_valid && diff_ready;

	assign p    = PROD_BITS'(diff.mag) * PROD_BITS'(gain_q);
	assign clip = diff.neg ? (p >= NEG_LIM) : (p >= POS_LIM);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dc_offset_q <= DC_OFFSET_RST;
			skip_q      <= SKIP_FRAMES_RST;
			gain_q      <= START_GAIN_RST;
			frames_q    <= '0;
			clip_seen_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_DC_OFFSET: begin
					dc_offset_q <= cfg_data[DC_BITS-1:0];
				end
				REG_START_GAIN: begin
					gain_q <= cfg_data[GAIN_BITS-1:0];
				end
				REG_SKIP_FRAMES: begin
					skip_q <= cfg_data[SKIP_BITS-1:0];
				end
				default: begin
				end
			endcase
		end else if (fire) begin
			if (diff.last && frames_q != FRAMES_MAX) begin
				frames_q <= frames_q + SKIP_BITS'(1);
			end
			if (!drop) begin
				if (diff.last) begin
					clip_seen_q <= 1'b0;
					if ((clip_seen_q || clip) && gain_q > GAIN_FLOOR) begin
						gain_q <= gain_q - GAIN_BITS'(1);
					end
				end else if (clip) begin
					clip_seen_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (fire && !drop) begin
			valid_s2 <= 1'b1;
		end else if (prod_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && !drop) begin
			prod_s2.neg  <= diff.neg;
			prod_s2.clip <= clip;
			prod_s2.mag  <= p[QMAG_BITS-1:0];
			prod_s2.last <= diff.last;
			prod_s2.gain <= gain_q;
		end
	end

	assign prod       = prod_s2;
	assign prod_valid = valid_s2;

endmodule

/* hdl/mgc_out.sv */
// mgc_out: divide by 100 through a reciprocal multiply, saturate, and hold the
// result item in the output register. Uses mgc_pkg.
module mgc_out import mgc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  prod_t   prod,
	input  logic    prod_valid,
	output logic    prod_ready,
	output result_t result,
	output logic    result_valid,
	input  logic    result_ready
);

	localparam logic [63:0] RECIP_FULL =
		((64'd1 << RECIP_SHIFT) + 64'(GAIN_DIV - 1)) / 64'(GAIN_DIV);
	localparam logic [QMAG_BITS:0] RECIP = RECIP_FULL[QMAG_BITS:0];
	localparam logic [SAMPLE_BITS-1:0] SAT_HI = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic [SAMPLE_BITS-1:0] SAT_LO = ~SAT_HI;

	logic [2*QMAG_BITS:0]   qprod;
	logic [SAMPLE_BITS-1:0] q;
	logic [SAMPLE_BITS-1:0] val;
	logic                   valid_q;
	result_t                result_q;

	assign qprod = (2*QMAG_BITS+1)'(prod.mag) * (2*QMAG_BITS+1)'(RECIP);
	assign q     = qprod[2*QMAG_BITS:RECIP_SHIFT];

	always_comb begin
		if (prod.clip) begin
			val = prod.neg ? SAT_LO : SAT_HI;
		end else begin
			val = prod.neg ? -q : q;
		end
	end

	assign prod_ready = !valid_q || result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (prod_ready) begin
			valid_q <= prod_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (prod_valid && prod_ready) begin
			result_q.clean_sample <= val;
			result_q.clipped      <= prod.clip;
			result_q.frame_last   <= prod.last;
			result_q.gain_used    <= prod.gain;
		end
	end

	assign result       = result_q;
	assign result_valid = valid_q;

endmodule
